/* rtl/swpe_pkg.sv */
// Shared types, constants and helpers of the sliding-window percentile estimator.
package swpe_pkg;

  localparam int WINDOW      = 512;
  localparam int NUM_CLASSES = 4;
  localparam int NUM_BINS    = 16;
  localparam int NBINS_TOTAL = NUM_CLASSES * NUM_BINS;

  localparam int BIN_W      = (NBINS_TOTAL > 1) ? $clog2(NBINS_TOTAL) : 1;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int RING_DEPTH = NBINS_TOTAL * WINDOW;
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  localparam int SMP_W     = 24;
  localparam int EST_W     = 26;
  localparam int ELAPSED_W = 40;
  localparam int PERC_W    = 7;

  localparam int CLAMP_SLOPE   = 96614;
  localparam int CLAMP_BASE    = 11564387;
  localparam int DEFAULT_SLOPE = 117187;
  localparam int PERC_MAX      = 100;
  localparam int PERC_RESET    = 98;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for x below about 1.8 million
  localparam int RECIP_100   = 1342178;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 27;
  localparam int X_W         = PERC_W + IDX_W;
  localparam int P_W         = X_W + RECIP_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_PERCENTILE = 3'h0;

  typedef logic [BIN_W-1:0]  bin_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SMP_W-1:0]  smp_t;
  typedef logic [EST_W-1:0]  est_t;
  typedef logic [X_W-1:0]    x_t;
  typedef logic [P_W-1:0]    prod_t;

  typedef struct packed {
    logic                 req_type;
    logic [1:0]           traffic_class;
    logic [3:0]           queue_depth;
    logic [ELAPSED_W-1:0] elapsed_ns;
  } in_item_t;

  typedef struct packed {
    logic [EST_W-1:0] expected_ns;
    logic             from_default;
  } out_item_t;

  typedef struct packed {
    idx_t cnt;
    idx_t head;
    est_t est;
  } meta_t;

  function automatic addr_t win_addr(bin_t b, idx_t i);
    return addr_t'(int'(b) * WINDOW + int'(i));
  endfunction

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(WINDOW - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

endpackage

/* rtl/swpe_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module swpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sliding_window_percentile_estimator_core.sv */
// Top level of the sliding-window percentile estimator of completion times.
//
// One window of completion-time samples is kept for each traffic class and queue-depth bin.
// A record item clamps its time, writes it into the bin's sample ring and keeps a sorted copy
// of the window in a second memory: when the ring is full, one pass walks the sorted copy and
// drops one occurrence of the oldest sample, then a second pass walks it again and inserts the
// new one. The (100-p)*n/100-th largest entry (at least the first) becomes the bin's estimate,
// or the linear default 117187*depth while the window holds fewer than half a window of samples.
// A query answers from the bin one depth lower under the same sparseness rule. Items are taken
// one at a time. A record into a window that is not yet full walks the sorted-window memory once
// to insert; once the window is full at 511 samples it walks it twice (511 entries to drop the
// oldest, 510 to insert), each walk reading one entry per cycle. Results sit in an output
// register, so the next item is taken while a result waits; a result that finds the register
// still occupied holds the block until the register drains. Per-bin head, count and estimate
// live in a small metadata memory whose entries read as zero until first written. The
// percentile register sits at byte address 0 of the APB port.
module sliding_window_percentile_estimator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  swpe_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output swpe_pkg::out_item_t                  out_item_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swpe_pkg::PADDR_W-1:0]         paddr,
  input  logic [swpe_pkg::PDATA_W-1:0]         pwdata,
  output logic [swpe_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_META, ST_OLD, ST_REM, ST_INS, ST_INSFIN, ST_KX, ST_KMUL,
    ST_KSEL, ST_EST, ST_QBELOW, ST_MWR, ST_RESULT
  } state_e;

  state_e                           state_q;
  logic                             req_q;
  logic [3:0]                       depth_q;
  swpe_pkg::bin_t                   bin_q;
  swpe_pkg::smp_t                   t_q;
  swpe_pkg::smp_t                   old_q;
  swpe_pkg::smp_t                   carry_q;
  swpe_pkg::idx_t                   cnt_q;
  swpe_pkg::idx_t                   head_q;
  swpe_pkg::idx_t                   len_q;
  swpe_pkg::idx_t                   iss_q;
  swpe_pkg::idx_t                   pidx_q;
  logic                             pv_q;
  logic                             found_q;
  logic                             placed_q;
  swpe_pkg::x_t                     x_q;
  swpe_pkg::prod_t                  prod_q;
  swpe_pkg::est_t                   res_est_q;
  logic                             res_dflt_q;
  logic [swpe_pkg::PERC_W-1:0]      perc_q;
  logic                             out_valid_q;
  swpe_pkg::out_item_t              out_item_q;
  logic [swpe_pkg::NBINS_TOTAL-1:0] mvalid_q;

  // ---------------------------------------------------------------- input decode
  logic           in_acc;
  logic           in_oob;
  swpe_pkg::bin_t in_bin;
  swpe_pkg::smp_t in_lim;
  swpe_pkg::smp_t in_t;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_oob = (int'(in_item_i.traffic_class) >= swpe_pkg::NUM_CLASSES) ||
                  (int'(in_item_i.queue_depth) >= swpe_pkg::NUM_BINS);
  assign in_bin = swpe_pkg::bin_t'(int'(in_item_i.traffic_class) * swpe_pkg::NUM_BINS +
                                   int'(in_item_i.queue_depth));
  assign in_lim = swpe_pkg::smp_t'(swpe_pkg::CLAMP_SLOPE * int'(in_item_i.queue_depth) +
                                   swpe_pkg::CLAMP_BASE);
  // Clamp the elapsed time to the bin's ceiling
  assign in_t = (in_item_i.elapsed_ns <
                 {{(swpe_pkg::ELAPSED_W - swpe_pkg::SMP_W){1'b0}}, in_lim}) ?
                in_item_i.elapsed_ns[swpe_pkg::SMP_W-1:0] : in_lim;

  // ---------------------------------------------------------------- memories
  logic                 m_re, m_we;
  swpe_pkg::bin_t       m_raddr;
  swpe_pkg::meta_t      m_rdata, m_wdata, meta_cur;
  logic                 r_re, r_we;
  swpe_pkg::addr_t      r_raddr, r_waddr;
  swpe_pkg::smp_t       r_rdata;
  logic                 s_re, s_we;
  swpe_pkg::addr_t      s_raddr, s_waddr;
  swpe_pkg::smp_t       s_rdata, s_wdata;
  swpe_pkg::idx_t       s_ridx, s_widx;

  swpe_ram #(.WIDTH($bits(swpe_pkg::meta_t)), .DEPTH(swpe_pkg::NBINS_TOTAL)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (bin_q),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  swpe_ram #(.WIDTH(swpe_pkg::SMP_W), .DEPTH(swpe_pkg::RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (t_q),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  swpe_ram #(.WIDTH(swpe_pkg::SMP_W), .DEPTH(swpe_pkg::RING_DEPTH)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // A metadata entry never written reads as zero
  assign meta_cur = mvalid_q[bin_q] ? m_rdata : '0;

  // ---------------------------------------------------------------- datapath helpers
  logic                        is_scan;
  logic                        scan_issue;
  logic                        scan_end;
  logic                        full;
  swpe_pkg::idx_t              head_nxt;
  swpe_pkg::est_t              dflt;
  logic [swpe_pkg::PERC_W-1:0] p_sat;
  logic [swpe_pkg::PERC_W-1:0] p_inv;
  swpe_pkg::idx_t              k_raw;
  swpe_pkg::idx_t              k_cl;
  swpe_pkg::bin_t              bin_below;
  logic                        out_free;

  assign is_scan    = (state_q == ST_REM) || (state_q == ST_INS);
  assign scan_issue = is_scan && (iss_q != len_q);
  assign scan_end   = is_scan && (iss_q == len_q) && !pv_q;
  assign full       = (meta_cur.cnt == swpe_pkg::idx_t'(swpe_pkg::WINDOW - 1));
  assign head_nxt   = swpe_pkg::idx_inc(meta_cur.head);
  assign dflt       = swpe_pkg::est_t'(swpe_pkg::DEFAULT_SLOPE * int'(depth_q));
  assign p_sat      = (int'(perc_q) > swpe_pkg::PERC_MAX) ?
                      swpe_pkg::PERC_W'(swpe_pkg::PERC_MAX) : perc_q;
  assign p_inv      = swpe_pkg::PERC_W'(swpe_pkg::PERC_MAX) - p_sat;
  assign k_raw      = prod_q[swpe_pkg::RECIP_SHIFT +: swpe_pkg::IDX_W];
  assign k_cl       = (k_raw == '0) ? swpe_pkg::idx_t'(1) : ((k_raw > cnt_q) ? cnt_q : k_raw);
  assign bin_below  = swpe_pkg::bin_t'(bin_q - 1'b1);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    m_re    = 1'b0;
    m_raddr = in_bin;
    m_we    = (state_q == ST_MWR);
    m_wdata = '{cnt: cnt_q, head: head_q, est: res_est_q};
    r_re    = 1'b0;
    r_we    = 1'b0;
    r_raddr = swpe_pkg::win_addr(bin_q, head_nxt);
    r_waddr = swpe_pkg::win_addr(bin_q, meta_cur.head);
    s_re    = scan_issue;
    s_ridx  = iss_q;
    s_we    = 1'b0;
    s_widx  = pidx_q;
    s_wdata = placed_q ? carry_q : t_q;
    case (state_q)
      ST_IDLE: begin
        m_re = in_acc && !in_oob;
      end
      ST_META: begin
        if (req_q) begin
          m_re    = 1'b1;
          m_raddr = bin_below;
        end else begin
          r_we = 1'b1;
          r_re = full;
        end
      end
      ST_REM: begin
        // Close the gap left by the dropped sample
        s_we    = pv_q && found_q;
        s_widx  = swpe_pkg::idx_t'(pidx_q - 1'b1);
        s_wdata = s_rdata;
      end
      ST_INS: begin
        s_we = pv_q && (placed_q || (s_rdata > t_q));
      end
      ST_INSFIN: begin
        s_we   = 1'b1;
        s_widx = len_q;
      end
      ST_KSEL: begin
        s_re   = 1'b1;
        s_ridx = swpe_pkg::idx_t'(cnt_q - k_cl);
      end
      default: begin
      end
    endcase
    s_raddr = swpe_pkg::win_addr(bin_q, s_ridx);
    s_waddr = swpe_pkg::win_addr(bin_q, s_widx);
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= 1'b0;
      depth_q     <= '0;
      bin_q       <= '0;
      t_q         <= '0;
      old_q       <= '0;
      carry_q     <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      len_q       <= '0;
      iss_q       <= '0;
      pidx_q      <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      placed_q    <= 1'b0;
      x_q         <= '0;
      prod_q      <= '0;
      res_est_q   <= '0;
      res_dflt_q  <= 1'b0;
      perc_q      <= swpe_pkg::PERC_W'(swpe_pkg::PERC_RESET);
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      mvalid_q    <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr == swpe_pkg::ADDR_PERCENTILE)) begin
        perc_q <= pwdata[swpe_pkg::PERC_W-1:0];
      end

      // Drop the output item once taken, unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      // Shared scan pipeline: issue one read per cycle, consume the data in the cycle after the read
      if (is_scan) begin
        pv_q   <= scan_issue;
        pidx_q <= iss_q;
        if (scan_issue) begin
          iss_q <= swpe_pkg::idx_t'(iss_q + 1'b1);
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            req_q   <= in_item_i.req_type;
            depth_q <= in_item_i.queue_depth;
            bin_q   <= in_bin;
            t_q     <= in_t;
            if (in_oob) begin
              res_est_q  <= '0;
              res_dflt_q <= 1'b0;
              state_q    <= ST_RESULT;
            end else begin
              state_q <= ST_META;
            end
          end
        end
        ST_META: begin
          if (req_q) begin
            if (int'(meta_cur.cnt) < swpe_pkg::WINDOW / 2) begin
              res_est_q  <= dflt;
              res_dflt_q <= 1'b1;
              state_q    <= ST_RESULT;
            end else if (depth_q == '0) begin
              res_est_q  <= '0;
              res_dflt_q <= 1'b0;
              state_q    <= ST_RESULT;
            end else begin
              state_q <= ST_QBELOW;
            end
          end else begin
            cnt_q    <= meta_cur.cnt;
            head_q   <= head_nxt;
            iss_q    <= '0;
            pv_q     <= 1'b0;
            found_q  <= 1'b0;
            placed_q <= 1'b0;
            if (full) begin
              state_q <= ST_OLD;
            end else begin
              len_q   <= meta_cur.cnt;
              state_q <= ST_INS;
            end
          end
        end
        ST_OLD: begin
          old_q   <= r_rdata;
          len_q   <= cnt_q;
          state_q <= ST_REM;
        end
        ST_REM: begin
          if (pv_q && !found_q && (s_rdata == old_q)) begin
            found_q <= 1'b1;
          end
          if (scan_end) begin
            len_q   <= swpe_pkg::idx_t'(len_q - 1'b1);
            iss_q   <= '0;
            state_q <= ST_INS;
          end
        end
        ST_INS: begin
          if (pv_q && (placed_q || (s_rdata > t_q))) begin
            carry_q  <= s_rdata;
            placed_q <= 1'b1;
          end
          if (scan_end) begin
            state_q <= ST_INSFIN;
          end
        end
        ST_INSFIN: begin
          cnt_q <= swpe_pkg::idx_t'(len_q + 1'b1);
          if ((int'(len_q) + 1) < swpe_pkg::WINDOW / 2) begin
            res_est_q  <= dflt;
            res_dflt_q <= 1'b1;
            state_q    <= ST_MWR;
          end else begin
            state_q <= ST_KX;
          end
        end
        ST_KX: begin
          x_q     <= swpe_pkg::x_t'(p_inv) * swpe_pkg::x_t'(cnt_q);
          state_q <= ST_KMUL;
        end
        ST_KMUL: begin
          prod_q  <= swpe_pkg::prod_t'(x_q) * swpe_pkg::prod_t'(swpe_pkg::RECIP_100);
          state_q <= ST_KSEL;
        end
        ST_KSEL: begin
          state_q <= ST_EST;
        end
        ST_EST: begin
          res_est_q  <= swpe_pkg::est_t'(s_rdata);
          res_dflt_q <= 1'b0;
          state_q    <= ST_MWR;
        end
        ST_QBELOW: begin
          res_est_q  <= mvalid_q[bin_below] ? m_rdata.est : '0;
          res_dflt_q <= 1'b0;
          state_q    <= ST_RESULT;
        end
        ST_MWR: begin
          mvalid_q[bin_q] <= 1'b1;
          state_q         <= ST_RESULT;
        end
        ST_RESULT: begin
          // Hold until the output register is free
          if (out_free) begin
            out_item_q  <= '{expected_ns: res_est_q, from_default: res_dflt_q};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == swpe_pkg::ADDR_PERCENTILE) ?
                       {{(swpe_pkg::PDATA_W - swpe_pkg::PERC_W){1'b0}}, perc_q} : '0;

  // ---------------------------------------------------------------- assertions
  // The walks never read and write the same sorted-window entry in one cycle
  a_no_rw_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_we && s_re) |-> (s_waddr != s_raddr))
    else $error("sorted window read and write collide");

  // The evicted sample is always present in the sorted window
  a_evict_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM && scan_end) |-> (found_q || (pv_q && s_rdata == old_q)))
    else $error("evicted sample missing from sorted window");

  // The reciprocal divide never ranks past the window's sample count
  a_rank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KSEL) |-> (k_raw <= cnt_q))
    else $error("rank exceeds window count");

  // A window never grows beyond one less than the ring size
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSFIN) |-> (int'(len_q) < swpe_pkg::WINDOW - 1))
    else $error("window overflow");

endmodule

/* tb/tb_sliding_window_percentile_estimator_core.sv */
// Self-checking testbench of the sliding-window percentile estimator core.
module tb_sliding_window_percentile_estimator_core;

  localparam int  TIMEOUT_CYCLES = 3_000_000;
  localparam int  DRAIN_CYCLES   = 40;
  localparam int  HOT_CLASS      = 2;
  localparam bit  REQ_RECORD     = 1'b0;
  localparam bit  REQ_QUERY      = 1'b1;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  swpe_pkg::in_item_t             in_item_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  swpe_pkg::out_item_t            out_item_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [swpe_pkg::PADDR_W-1:0]   paddr = '0;
  logic [swpe_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [swpe_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  sliding_window_percentile_estimator_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Predicted state of every bin: sample ring, ascending window copy, pointers, estimate.
  logic [swpe_pkg::SMP_W-1:0] ring_mem [swpe_pkg::NBINS_TOTAL][swpe_pkg::WINDOW];
  logic [swpe_pkg::SMP_W-1:0] sorted_mem [swpe_pkg::NBINS_TOTAL][swpe_pkg::WINDOW];
  int unsigned                head_ptr [swpe_pkg::NBINS_TOTAL];
  int unsigned                tail_ptr [swpe_pkg::NBINS_TOTAL];
  int unsigned                fill_cnt [swpe_pkg::NBINS_TOTAL];
  logic [swpe_pkg::EST_W-1:0] stored_est [swpe_pkg::NBINS_TOTAL];
  int unsigned                cur_percentile;

  swpe_pkg::in_item_t  pending_items [$];
  swpe_pkg::out_item_t expected_results [$];
  int        errors = 0;
  int        results_seen = 0;
  int        records_sent = 0;
  int        queries_sent = 0;
  int        evictions = 0;
  int        cycle_cnt = 0;

  // Work out one item's result and advance the predicted state.
  function automatic swpe_pkg::out_item_t estimate_item(swpe_pkg::in_item_t it);
    swpe_pkg::out_item_t        res;
    int unsigned                b, d, n, pos, p, k;
    longint unsigned            lim;
    logic [swpe_pkg::SMP_W-1:0] t, old;
    logic [swpe_pkg::EST_W-1:0] dflt;
    bit                         found;
    res = '0;
    d = it.queue_depth;
    b = it.traffic_class * swpe_pkg::NUM_BINS + d;
    dflt = swpe_pkg::EST_W'(swpe_pkg::DEFAULT_SLOPE * d);
    if (it.req_type == REQ_RECORD) begin
      lim = longint'(swpe_pkg::CLAMP_SLOPE) * d + swpe_pkg::CLAMP_BASE;
      t = swpe_pkg::SMP_W'((it.elapsed_ns < lim) ? it.elapsed_ns : lim);
      // insert into the ascending copy after every equal entry
      n = fill_cnt[b];
      pos = 0;
      while (pos < n && sorted_mem[b][pos] <= t) pos++;
      for (int i = n; i > pos; i--) sorted_mem[b][i] = sorted_mem[b][i-1];
      sorted_mem[b][pos] = t;
      fill_cnt[b]++;
      // ring full: drop one occurrence of the oldest sample
      if ((head_ptr[b] + 1) % swpe_pkg::WINDOW == tail_ptr[b]) begin
        old = ring_mem[b][tail_ptr[b]];
        found = 1'b0;
        n = fill_cnt[b];
        for (int i = 0; i < n; i++) begin
          if (!found && sorted_mem[b][i] == old) found = 1'b1;
          if (found && i < n - 1) sorted_mem[b][i] = sorted_mem[b][i+1];
        end
        if (found) fill_cnt[b]--;
        tail_ptr[b] = (tail_ptr[b] + 1) % swpe_pkg::WINDOW;
        evictions++;
      end
      ring_mem[b][head_ptr[b]] = t;
      head_ptr[b] = (head_ptr[b] + 1) % swpe_pkg::WINDOW;
      n = fill_cnt[b];
      if (n < swpe_pkg::WINDOW / 2) begin
        res.expected_ns  = dflt;
        res.from_default = 1'b1;
      end else begin
        p = (cur_percentile > swpe_pkg::PERC_MAX) ? swpe_pkg::PERC_MAX : cur_percentile;
        k = (100 - p) * n / 100;
        if (k < 1) k = 1;
        if (k > n) k = n;
        res.expected_ns = swpe_pkg::EST_W'(sorted_mem[b][n-k]);
      end
      stored_est[b] = res.expected_ns;
    end else begin
      n = fill_cnt[b];
      if (n < swpe_pkg::WINDOW / 2) begin
        res.expected_ns  = dflt;
        res.from_default = 1'b1;
      end else if (d == 0) begin
        res.expected_ns = '0;
      end else begin
        res.expected_ns = stored_est[b-1];
      end
    end
    return res;
  endfunction

  // Cycle counter and timeout guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: send pending items in bursts, with random gaps between bursts.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: switch between free flow, light and heavy stalling.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_cnt % 1500 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Monitor: predict on input handshakes, check on output handshakes.
  always @(posedge clk_i) begin
    swpe_pkg::out_item_t want;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_results.push_back(estimate_item(in_item_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected_ns=%0d from_default=%0b", $time,
                 out_item_o.expected_ns, out_item_o.from_default);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.expected_ns !== want.expected_ns) begin
          $display("%0t: expected_ns mismatch: expected %0d actual %0d", $time,
                   want.expected_ns, out_item_o.expected_ns);
          errors++;
        end
        if (out_item_o.from_default !== want.from_default) begin
          $display("%0t: from_default mismatch: expected %0b actual %0b", $time,
                   want.from_default, out_item_o.from_default);
          errors++;
        end
      end
    end
  end

  function automatic longint unsigned clamp_limit(int unsigned d);
    return longint'(swpe_pkg::CLAMP_SLOPE) * d + swpe_pkg::CLAMP_BASE;
  endfunction

  task automatic add_item(bit req, int unsigned cls, int unsigned d, longint unsigned el);
    swpe_pkg::in_item_t it;
    it.req_type      = req;
    it.traffic_class = 2'(cls);
    it.queue_depth   = 4'(d);
    it.elapsed_ns    = swpe_pkg::ELAPSED_W'(el);
    pending_items.push_back(it);
    if (req == REQ_RECORD) records_sent++;
    else queries_sent++;
  endtask

  // Mix of repeated values, values near, above and below the clamp, and full-width noise.
  function automatic longint unsigned pick_elapsed(int unsigned d);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return longint'($urandom_range(0, 7)) * 1_000_000 + 250_000;
    if (sel == 3) return clamp_limit(d) + $urandom_range(0, 2) - 1;
    if (sel == 4) return {$urandom, $urandom} & 40'hFF_FFFF_FFFF;
    return $urandom_range(0, int'(clamp_limit(d)));
  endfunction

  task automatic apb_write(logic [swpe_pkg::PADDR_W-1:0] addr,
                           logic [swpe_pkg::PDATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == swpe_pkg::ADDR_PERCENTILE) cur_percentile = data & 32'h7F;
  endtask

  task automatic apb_check(logic [swpe_pkg::PADDR_W-1:0] addr,
                           logic [swpe_pkg::PDATA_W-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register readback mismatch: expected %0d actual %0d", $time,
               want, prdata);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Hold until nothing is queued, in flight or awaited, then let the block settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Drive one hot bin with records, mixed with queries and records elsewhere.
  task automatic hot_phase(int unsigned perc, int unsigned hot_depth, int unsigned n_hot);
    int unsigned sel, d;
    wait_idle();
    apb_write(swpe_pkg::ADDR_PERCENTILE, perc);
    apb_check(swpe_pkg::ADDR_PERCENTILE, perc & 32'h7F);
    while (n_hot > 0) begin
      sel = $urandom_range(0, 19);
      if (sel < 1) begin
        d = $urandom_range(0, swpe_pkg::NUM_BINS - 1);
        add_item(REQ_RECORD, $urandom_range(0, swpe_pkg::NUM_CLASSES - 1), d,
                 pick_elapsed(d));
      end else if (sel < 2) begin
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, swpe_pkg::NUM_BINS - 1)
                                        : $urandom_range(0, 2);
        add_item(REQ_QUERY, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : HOT_CLASS,
                 d, {$urandom, $urandom});
      end else begin
        add_item(REQ_RECORD, HOT_CLASS, hot_depth, pick_elapsed(hot_depth));
        n_hot--;
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int b = 0; b < swpe_pkg::NBINS_TOTAL; b++) begin
      head_ptr[b] = 0; tail_ptr[b] = 0; fill_cnt[b] = 0; stored_est[b] = '0;
    end
    cur_percentile = swpe_pkg::PERC_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and clamp edges, all in sparse windows at reset percentile.
    apb_check(swpe_pkg::ADDR_PERCENTILE, swpe_pkg::PERC_RESET);
    add_item(REQ_RECORD, 0, 0, 0);
    add_item(REQ_RECORD, 3, 15, 40'hFF_FFFF_FFFF);
    add_item(REQ_RECORD, 0, 0, clamp_limit(0));
    add_item(REQ_RECORD, 0, 0, clamp_limit(0) + 1);
    add_item(REQ_RECORD, 3, 15, clamp_limit(15) - 1);
    add_item(REQ_RECORD, 1, 10, clamp_limit(10));
    add_item(REQ_RECORD, 2, 5, 40'h55_5555_5555);
    add_item(REQ_RECORD, 1, 10, 40'hAA_AAAA_AAAA);
    add_item(REQ_QUERY, 0, 0, 0);
    add_item(REQ_QUERY, 3, 15, 40'hFF_FFFF_FFFF);
    add_item(REQ_QUERY, 1, 10, 0);
    add_item(REQ_QUERY, 2, 7, 12345);
    wait_idle();

    // Seed the depth-0 estimate, then fill the depth-1 bin dense.
    hot_phase(0, 0, 8);
    add_item(REQ_QUERY, HOT_CLASS, 0, 0);
    hot_phase(127, 1, 265);
    // Dense depth-1 bin now answers from the depth-0 estimate.
    add_item(REQ_QUERY, HOT_CLASS, 1, 0);
    hot_phase(swpe_pkg::PERC_MAX, 1, 90);
    hot_phase(0, 1, 60);
    hot_phase(50, 1, 60);
    hot_phase($urandom_range(0, 127), 1, 40);

    $display("covered %0d records and %0d queries, %0d results checked, %0d evictions",
             records_sent, queries_sent, results_seen, evictions);
    $display("percentile settings 98, 0, 127, 100, 50 and one random value");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swpe_pkg.sv
rtl/swpe_ram.sv
rtl/sliding_window_percentile_estimator_core.sv
tb/tb_sliding_window_percentile_estimator_core.sv
